FILE: design/u64dd_pkg.sv
// shared types and constants for the 64-bit binary to decimal digit converter
// used by u64dd_cell, u64dd_conv and uint64_to_decimal_digits
`default_nettype none
package u64dd_pkg;

  localparam int unsigned VALUE_W         = 64;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned NUM_DIGITS      = 20;
  localparam int unsigned BITS_PER_CYCLE  = 4;
  localparam int unsigned CONV_CYCLES     = VALUE_W / BITS_PER_CYCLE;
  localparam int unsigned CONV_CNT_W      = $clog2(CONV_CYCLES);
  localparam int unsigned REMAIN_W        = $clog2(NUM_DIGITS + 1);
  localparam int unsigned OUT_TDATA_W     = 8;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_row_t;
  typedef logic [BITS_PER_CYCLE-1:0] shift_bits_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_RUN,
    CV_DONE
  } conv_state_t;

  // the add-3 correction of one shift-and-add-3 step on a single bcd digit
  function automatic digit_t dabble_adj(input digit_t d);
    dabble_adj = (d >= digit_t'(5)) ? digit_t'(d + digit_t'(3)) : d;
  endfunction

endpackage
`default_nettype wire

FILE: design/u64dd_cell.sv
// one bcd digit of the double-dabble row, takes four shift steps per cycle while en is high
// depends on u64dd_pkg
`default_nettype none
module u64dd_cell (
  input  wire logic                    clk,
  input  wire logic                    clear,
  input  wire logic                    en,
  input  wire u64dd_pkg::shift_bits_t  in_bits,   // msb is the first step
  output      u64dd_pkg::shift_bits_t  out_bits,  // msb is the first step
  output      u64dd_pkg::digit_t       digit
);
  import u64dd_pkg::*;

  digit_t digit_next;

  always_comb begin
    digit_t d;
    digit_t a;
    d = digit;
    out_bits = '0;
    for (int j = 0; j < BITS_PER_CYCLE; j++) begin
      a = dabble_adj(d);
      out_bits[BITS_PER_CYCLE-1-j] = a[DIGIT_W-1];
      d = {a[DIGIT_W-2:0], in_bits[BITS_PER_CYCLE-1-j]};
    end
    digit_next = d;
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      digit <= '0;
    end else if (en) begin
      digit <= digit_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/u64dd_conv.sv
// converter: binary shift register feeding a row of double-dabble digit cells
// depends on u64dd_pkg and u64dd_cell
`default_nettype none
module u64dd_conv (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [63:0]         value,
  output      logic                done,
  input  wire logic                take,
  output      u64dd_pkg::bcd_row_t digits
);
  import u64dd_pkg::*;

  conv_state_t state, state_next;
  logic [CONV_CNT_W-1:0] cnt;
  logic [VALUE_W-1:0]    bin;
  logic                  start;
  logic                  running;
  shift_bits_t           link [NUM_DIGITS];

  assign in_ready = (state == CV_IDLE);
  assign done     = (state == CV_DONE);
  assign start    = in_valid && in_ready;
  assign running  = (state == CV_RUN);
  assign link[0]  = bin[VALUE_W-1 -: BITS_PER_CYCLE];

  always_comb begin
    state_next = state;
    case (state)
      CV_IDLE: begin
        if (start) state_next = CV_RUN;
      end
      CV_RUN: begin
        if (cnt == CONV_CNT_W'(CONV_CYCLES - 1)) state_next = CV_DONE;
      end
      CV_DONE: begin
        if (take) state_next = CV_IDLE;
      end
      default: state_next = CV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CV_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        cnt <= '0;
      end else if (running) begin
        cnt <= cnt + CONV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
    end else if (running) begin
      bin <= {bin[VALUE_W-BITS_PER_CYCLE-1:0], BITS_PER_CYCLE'(0)};
    end
  end

  // cell 0 is the least significant digit and takes the binary bits
  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
    if (k < NUM_DIGITS - 1) begin : g_mid
      u64dd_cell u_cell (
        .clk      (clk),
        .clear    (start),
        .en       (running),
        .in_bits  (link[k]),
        .out_bits (link[k+1]),
        .digit    (digits[k])
      );
    end else begin : g_top
      // value stays below 10^20, nothing leaves the top digit
      u64dd_cell u_cell (
        .clk      (clk),
        .clear    (start),
        .en       (running),
        .in_bits  (link[k]),
        .out_bits (),
        .digit    (digits[k])
      );
    end
  end

endmodule
`default_nettype wire

FILE: design/uint64_to_decimal_digits.sv
// top level: 64-bit unsigned value in, decimal digits out one beat each
// depends on u64dd_pkg and u64dd_conv
//
// Input channel s_*: one beat carries a 64-bit unsigned value in s_tdata.
// Output channel m_*: one beat per decimal digit, most significant first,
// leading zeros dropped; m_tlast marks the least significant digit. A value
// of zero gives a single digit 0 with m_tlast set.
// Conversion runs in a row of 20 bcd digit cells, four binary bits shifted
// in per cycle. The finished digits move into an output shift line, so the
// next value converts while the previous one is still being sent. The output
// line has 20 digit slots, sent or skipped in turn, and these slots set the
// sustained rate of values; a leading zero is skipped without m_tready.
// Reset (rst, synchronous) empties both the converter and the output line.
// When m_tready is low the current digit holds on m_tdata; the converter
// finishes its value and waits, and s_tready stays low until it is free.
`default_nettype none
module uint64_to_decimal_digits (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [63:0] s_tdata,   // [63:0] value
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [7:0]  m_tdata,   // [3:0] digit, [7:4] zero
  output      logic        m_tlast
);
  import u64dd_pkg::*;

  bcd_row_t              conv_digits;
  logic                  conv_done;
  logic                  take;
  bcd_row_t              sh;
  logic [REMAIN_W-1:0]   remain;
  logic                  started;
  logic                  busy;
  logic                  show;
  logic                  advance;
  digit_t                top_digit;

  u64dd_conv u_conv (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .value    (s_tdata),
    .done     (conv_done),
    .take     (take),
    .digits   (conv_digits)
  );

  assign busy      = (remain != '0);
  assign top_digit = sh[NUM_DIGITS-1];
  // a digit goes out once a nonzero one was seen, and the units digit always
  assign show      = started || (top_digit != '0) || (remain == REMAIN_W'(1));
  assign advance   = busy && (!show || m_tready);
  assign take      = conv_done && (!busy || (remain == REMAIN_W'(1) && advance));

  assign m_tvalid = busy && show;
  assign m_tdata  = {(OUT_TDATA_W - DIGIT_W)'(0), top_digit};
  assign m_tlast  = (remain == REMAIN_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      remain  <= '0;
      started <= 1'b0;
    end else if (take) begin
      remain  <= REMAIN_W'(NUM_DIGITS);
      started <= 1'b0;
    end else if (advance) begin
      remain  <= remain - REMAIN_W'(1);
      started <= started || show;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sh <= conv_digits;
    end else if (advance) begin
      sh <= {sh[NUM_DIGITS-2:0], DIGIT_W'(0)};
    end
  end

endmodule
`default_nettype wire

FILE: bench/tb.sv
// self-checking bench for uint64_to_decimal_digits: values in, decimal digit beats out
// depends on u64dd_pkg and the design files; digits predicted by repeated division by ten or taken from directed text
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import u64dd_pkg::*;

  typedef struct packed {
    digit_t digit;
    logic   last;
  } digit_beat_t;

  localparam int DIR_N = 20;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [VALUE_W-1:0] s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;
  logic               m_tlast;

  digit_beat_t digit_q[$];
  int          errors = 0;
  int          values_sent = 0;
  int          beats_checked = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          len_seen[1:NUM_DIGITS];

  // directed values; an empty text means the predictor supplies the digits
  logic [VALUE_W-1:0] dir_value[DIR_N] = '{
    64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
    64'd9999999999999999999, 64'd10000000000000000000, 64'd18446744073709551615,
    64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 64'h5555_5555_5555_5555,
    64'haaaa_aaaa_aaaa_aaaa, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
    64'h0000_0001_0000_0000, 64'h0000_0000_ffff_ffff, 64'd1000000000,
    64'd10000000000000000001, 64'd18446744073709551614
  };
  string dir_text[DIR_N] = '{
    "0", "1", "9", "10", "99", "100",
    "9999999999999999999", "10000000000000000000", "18446744073709551615",
    "", "", "", "", "", "", "", "", "1000000000", "", ""
  };

  uint64_to_decimal_digits dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // decimal digits of v, most significant first, last mark on the final one
  function automatic int queue_decimal_digits(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] rest;
    digit_t             rev[$];
    digit_beat_t        b;
    rest = v;
    do begin
      rev.push_back(digit_t'(rest % 64'd10));
      rest = rest / 64'd10;
    end while (rest != 0);
    for (int i = rev.size() - 1; i >= 0; i--) begin
      b.digit = rev[i];
      b.last  = (i == 0);
      digit_q.push_back(b);
    end
    return rev.size();
  endfunction

  function automatic int queue_digit_text(input string s);
    digit_beat_t b;
    for (int i = 0; i < s.len(); i++) begin
      b.digit = digit_t'(s[i] - 8'd48);
      b.last  = (i == s.len() - 1);
      digit_q.push_back(b);
    end
    return s.len();
  endfunction

  function automatic logic [VALUE_W-1:0] power_of_ten(input int k);
    logic [VALUE_W-1:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) p = p * 64'd10;
    return p;
  endfunction

  // mix of full-width, short, near power of ten, tiny and near-max values
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] full;
    int                 w;
    full = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1: return full;
      2, 3, 4: begin
        w = $urandom_range(1, 64);
        return (w == 64) ? full : full & ((64'd1 << w) - 64'd1);
      end
      5: return power_of_ten($urandom_range(0, 19)) + 64'($urandom_range(0, 2)) - 64'd1;
      6: return 64'($urandom_range(0, 20));
      default: return 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 1000));
    endcase
  endfunction

  task automatic send_value(input logic [VALUE_W-1:0] v, input string text);
    int n;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, $urandom};
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    n = (text.len() != 0) ? queue_digit_text(text) : queue_decimal_digits(v);
    len_seen[n] = 1'b1;
    values_sent++;
  endtask

  task automatic drain_digits();
    s_tvalid <= 1'b0;
    while (digit_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : digit_check
    digit_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (digit_q.size() == 0) begin
        $error("digit beat with nothing expected: digit %0d last %0b", m_tdata[3:0], m_tlast);
        errors++;
      end else begin
        want = digit_q.pop_front();
        beats_checked++;
        if (m_tdata[3:0] !== want.digit) begin
          $error("digit: expected %0d, got %0d", want.digit, m_tdata[3:0]);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_tlast);
          errors++;
        end
        if (m_tdata[7:4] !== 4'd0) begin
          $error("pad: expected 0, got %0h", m_tdata[7:4]);
          errors++;
        end
      end
    end
  end

  initial begin
    int lens;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender idles 38%, receiver 85%
    send_idle_pct = 38;
    recv_idle_pct = 85;
    for (int i = 0; i < DIR_N; i++) send_value(dir_value[i], dir_text[i]);
    for (int i = 0; i < 130; i++) send_value(pick_value(), "");
    drain_digits();

    // roles swapped
    send_idle_pct = 85;
    recv_idle_pct = 38;
    for (int i = 0; i < 150; i++) send_value(pick_value(), "");
    drain_digits();

    // full speed on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 150; i++) send_value(pick_value(), "");
    drain_digits();
    repeat (40) @(posedge clk);

    lens = 0;
    for (int k = 1; k <= NUM_DIGITS; k++) lens += len_seen[k];
    $display("converted %0d values, checked %0d digit beats", values_sent, beats_checked);
    $display("%0d of %0d digit counts exercised, three handshake pacing phases",
             lens, NUM_DIGITS);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
